// ===== hdl/crsf_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the CRSF frame parser.
package crsf_pkg;

  // Largest frame the parser accepts: length bytes must stay below this count.
  localparam int unsigned FRAME_BYTES = 64;

  // Width of the byte counter, able to hold FRAME_BYTES itself.
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

  // Width of the stored length byte, which is always below FRAME_BYTES.
  localparam int unsigned LEN_W = $clog2(FRAME_BYTES);

  // Width of the reported byte position.
  localparam int unsigned IDX_W = 6;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_OWN_ADDRESS      = 2'd0,
    REG_SYNC_BYTE        = 2'd1,
    REG_ACCEPT_BROADCAST = 2'd2,
    REG_CRC_POLYNOMIAL   = 2'd3
  } cfg_reg_t;

  // Parser phase; the unused code behaves as hunt.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Register reset values.
  localparam logic [7:0] OWN_ADDRESS_RST = 8'd234;
  localparam logic [7:0] SYNC_BYTE_RST   = 8'd200;
  localparam logic [7:0] CRC_POLY_RST    = 8'd213;

  // Broadcast address that may start a frame when enabled.
  localparam logic [7:0] BROADCAST_ADDR = 8'h00;

  // One byte of an MSB-first CRC-8 update.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crsf_frame_parser_crc8_top.sv =====
// CRSF frame parser: input register, framing and CRC-8 check, result register.
//
// Takes one received byte per request and returns one result per byte: the byte, its
// position in the frame, whether it belongs to a frame, and on the CRC byte whether the
// CRC-8 of the body matched. A frame starts on the sync byte, the own address, or the
// broadcast address 0x00 when enabled; the next byte is the length (nonzero, below
// FRAME_BYTES). A byte goes through the input register, then the result register. The
// parser accepts a new byte every cycle unless out_ready stalls it; the byte-wide CRC
// update, combinational between the registers, sets that rate. Configuration must be
// written via cfg_write/cfg_index/cfg_data while no byte is in flight; not enforced.
module crsf_frame_parser_crc8_top (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  // Output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  byte_value,
  output logic [crsf_pkg::IDX_W-1:0]  byte_index,
  output logic                        in_frame,
  output logic                        frame_ok,
  output logic                        frame_bad
);

  localparam int unsigned CNT_W = crsf_pkg::CNT_W;
  localparam int unsigned LEN_W = crsf_pkg::LEN_W;
  localparam int unsigned IDX_W = crsf_pkg::IDX_W;

  // Configuration registers
  logic [7:0] own_address;
  logic [7:0] sync_byte;
  logic       accept_broadcast;
  logic [7:0] crc_polynomial;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Parser state
  crsf_pkg::phase_t  phase, phase_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [7:0]        running_crc, running_crc_next;

  // Result of the byte held in the input register
  logic [IDX_W-1:0]  idx_c;
  logic              inf_c, ok_c, bad_c;

  logic out_free;
  logic s1_fire;

  // Decoded conditions
  logic is_start;
  logic len_ok;
  logic body_room;
  logic crc_pos;

  // Handshake: the input register refills whenever its byte moves on
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address      <= crsf_pkg::OWN_ADDRESS_RST;
      sync_byte        <= crsf_pkg::SYNC_BYTE_RST;
      accept_broadcast <= 1'b0;
      crc_polynomial   <= crsf_pkg::CRC_POLY_RST;
    end else if (cfg_write) begin
      case (crsf_pkg::cfg_reg_t'(cfg_index))
        crsf_pkg::REG_OWN_ADDRESS:      own_address      <= cfg_data;
        crsf_pkg::REG_SYNC_BYTE:        sync_byte        <= cfg_data;
        crsf_pkg::REG_ACCEPT_BROADCAST: accept_broadcast <= cfg_data[0];
        crsf_pkg::REG_CRC_POLYNOMIAL:   crc_polynomial   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // Shared decode of the held byte against the current state
  assign is_start  = (s1_byte == sync_byte) || (s1_byte == own_address) ||
                     (accept_broadcast && (s1_byte == crsf_pkg::BROADCAST_ADDR));
  assign len_ok    = (s1_byte != 8'd0) && ({1'b0, s1_byte} < 9'(crsf_pkg::FRAME_BYTES));
  assign body_room = byte_count < CNT_W'(crsf_pkg::FRAME_BYTES);
  assign crc_pos   = byte_count == (CNT_W'(frame_length) + CNT_W'(1));

  // Next phase
  always_comb begin
    case (phase)
      crsf_pkg::PH_LEN: begin
        phase_next = len_ok ? crsf_pkg::PH_BODY : crsf_pkg::PH_HUNT;
      end
      crsf_pkg::PH_BODY: begin
        if (body_room && !crc_pos) begin
          phase_next = crsf_pkg::PH_BODY;
        end else begin
          phase_next = crsf_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = is_start ? crsf_pkg::PH_LEN : crsf_pkg::PH_HUNT;
      end
    endcase
  end

  // Counters, CRC and result fields
  always_comb begin
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    running_crc_next  = running_crc;
    idx_c             = '0;
    inf_c             = 1'b0;
    ok_c              = 1'b0;
    bad_c             = 1'b0;
    case (phase)
      crsf_pkg::PH_LEN: begin
        idx_c = IDX_W'(1);
        if (len_ok) begin
          frame_length_next = s1_byte[LEN_W-1:0];
          running_crc_next  = 8'd0;
          byte_count_next   = CNT_W'(2);
          inf_c             = 1'b1;
        end
      end
      crsf_pkg::PH_BODY: begin
        idx_c = IDX_W'(byte_count);
        if (body_room) begin
          inf_c = 1'b1;
          if (crc_pos) begin
            ok_c  = (s1_byte == running_crc);
            bad_c = (s1_byte != running_crc);
          end else begin
            running_crc_next = crsf_pkg::crc8_feed(running_crc, s1_byte, crc_polynomial);
          end
          byte_count_next = byte_count + CNT_W'(1);
        end
      end
      default: begin
        if (is_start) begin
          inf_c           = 1'b1;
          byte_count_next = CNT_W'(2);
        end
      end
    endcase
  end

  // State advances once per byte that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= crsf_pkg::PH_HUNT;
      byte_count   <= '0;
      frame_length <= '0;
      running_crc  <= 8'd0;
    end else if (s1_fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      running_crc  <= running_crc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      byte_value <= s1_byte;
      byte_index <= idx_c;
      in_frame   <= inf_c;
      frame_ok   <= ok_c;
      frame_bad  <= bad_c;
    end
  end

`ifndef SYNTHESIS
  // A CRC byte is either good or bad, never both.
  a_ok_bad_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_ok && frame_bad))
    else $error("frame_ok and frame_bad both set");

  // A CRC verdict only comes on a body byte that belongs to a frame.
  a_verdict_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_ok || frame_bad)) |-> (in_frame && (byte_index != IDX_W'(0))))
    else $error("CRC verdict outside a frame body");

  // A held byte is not lost while the result register is stalled.
  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_byte)))
    else $error("pending byte dropped under stall");

  // In the body phase the counter has passed the length byte.
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == crsf_pkg::PH_BODY) |-> (byte_count >= CNT_W'(2)))
    else $error("body phase with counter below two");
`endif

endmodule
